[src/qbf_pkg.sv]
// shared widths, constants and control types for the bezier flattener
package qbf_pkg;

	localparam int COORD_W          = 24;
	localparam int CNT_W            = 7;
	localparam int FRAC_W           = 16;
	localparam int U_W              = FRAC_W + 1;
	localparam int W_W              = FRAC_W + 1;
	localparam int P_W              = COORD_W + W_W + 1;
	localparam int S_W              = P_W + 2;
	localparam int DIV_STEPS        = U_W;
	localparam int DIV_CNT_W        = $clog2(DIV_STEPS + 1);
	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int MIN_SEGMENTS     = 2;

	localparam logic [U_W-1:0] ONE_Q16 = U_W'(1) << FRAC_W;

	// one curve as taken from the request channel
	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] ctrl_x;
		logic signed [COORD_W-1:0] ctrl_y;
		logic signed [COORD_W-1:0] finish_x;
		logic signed [COORD_W-1:0] finish_y;
		logic        [CNT_W-1:0]   segment_count;
	} qbf_curve_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic div_step;
		logic issue;
		logic last;
	} qbf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic             en;
		logic             busy;
		logic [CNT_W-1:0] n;
	} qbf_sts_t;

endpackage

[src/qbf_in_if.sv]
// curve request channel
interface qbf_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [qbf_pkg::COORD_W-1:0]  start_x;
	logic signed [qbf_pkg::COORD_W-1:0]  start_y;
	logic signed [qbf_pkg::COORD_W-1:0]  ctrl_x;
	logic signed [qbf_pkg::COORD_W-1:0]  ctrl_y;
	logic signed [qbf_pkg::COORD_W-1:0]  finish_x;
	logic signed [qbf_pkg::COORD_W-1:0]  finish_y;
	logic        [qbf_pkg::CNT_W-1:0]    segment_count;

	modport source (output valid, start_x, start_y, ctrl_x, ctrl_y, finish_x, finish_y,
		segment_count, input ready);
	modport sink (input valid, start_x, start_y, ctrl_x, ctrl_y, finish_x, finish_y,
		segment_count, output ready);
endinterface

[src/qbf_out_if.sv]
// line segment result channel
interface qbf_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [qbf_pkg::COORD_W-1:0]  seg_from_x;
	logic signed [qbf_pkg::COORD_W-1:0]  seg_from_y;
	logic signed [qbf_pkg::COORD_W-1:0]  seg_to_x;
	logic signed [qbf_pkg::COORD_W-1:0]  seg_to_y;
	logic                                last_segment;

	modport source (output valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y, last_segment,
		input ready);
	modport sink (input valid, seg_from_x, seg_from_y, seg_to_x, seg_to_y, last_segment,
		output ready);
endinterface

[src/qbf_datapath.sv]
// divider, parameter accumulator, weight and product pipeline, output register
module qbf_datapath #(
	parameter int MAX_SEGMENTS = qbf_pkg::MAX_SEGMENTS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  qbf_pkg::qbf_curve_t curve,
	input  qbf_pkg::qbf_cmd_t  cmd,
	output qbf_pkg::qbf_sts_t  sts,
	qbf_out_if.source          seg
);
	localparam int NW = $clog2(MAX_SEGMENTS + 1);

	logic signed [qbf_pkg::COORD_W-1:0] sx_q, sy_q, cx_q, cy_q, fx_q, fy_q;
	logic signed [qbf_pkg::COORD_W-1:0] prev_x_q, prev_y_q;
	logic [qbf_pkg::CNT_W-1:0] n_q, n_clamped;

	// restoring divider: 65536 / n
	logic [qbf_pkg::U_W-1:0] qd_q;
	logic [NW-1:0]           rem_q;
	logic [NW:0]             rem_sh;
	logic                    rem_ge;

	// parameter accumulator u = floor(i * 65536 / n)
	logic [qbf_pkg::U_W-1:0] u_q, u_nxt;
	logic [NW-1:0]           acc_q;
	logic [NW:0]             acc_sum;
	logic                    acc_carry;

	logic                    valid_s1, last_s1;
	logic [qbf_pkg::U_W-1:0] u_s1, v_s1;
	logic                    valid_s2, last_s2;
	logic [qbf_pkg::W_W-1:0] w0_s2, w1_s2, w2_s2;
	logic [2*qbf_pkg::U_W-1:0] vv, uv, uu;
	logic                    valid_s3, last_s3;
	logic signed [qbf_pkg::P_W-1:0] px0_s3, px1_s3, px2_s3, py0_s3, py1_s3, py2_s3;
	logic signed [qbf_pkg::S_W-1:0] sum_x, sum_y;
	logic signed [qbf_pkg::COORD_W-1:0] pt_x, pt_y;

	logic out_valid_q, en;

	always_comb begin
		if (int'(curve.segment_count) < qbf_pkg::MIN_SEGMENTS) begin
			n_clamped = qbf_pkg::CNT_W'(qbf_pkg::MIN_SEGMENTS);
		end else if (int'(curve.segment_count) > MAX_SEGMENTS) begin
			n_clamped = qbf_pkg::CNT_W'(MAX_SEGMENTS);
		end else begin
			n_clamped = curve.segment_count;
		end
	end

	assign rem_sh = {rem_q, qd_q[qbf_pkg::U_W-1]};
	assign rem_ge = (qbf_pkg::CNT_W+1)'(rem_sh) >= (qbf_pkg::CNT_W+1)'(n_q);

	assign acc_sum   = (NW+1)'(acc_q) + (NW+1)'(rem_q);
	assign acc_carry = (qbf_pkg::CNT_W+1)'(acc_sum) >= (qbf_pkg::CNT_W+1)'(n_q);
	assign u_nxt     = u_q + qd_q + qbf_pkg::U_W'(acc_carry);

	assign en = !out_valid_q || seg.ready;

	assign vv = v_s1 * v_s1;
	assign uv = u_s1 * v_s1;
	assign uu = u_s1 * u_s1;

	// sums of the three weighted points, floored by the arithmetic shift
	assign sum_x = qbf_pkg::S_W'(px0_s3) + qbf_pkg::S_W'(px1_s3) + qbf_pkg::S_W'(px2_s3);
	assign sum_y = qbf_pkg::S_W'(py0_s3) + qbf_pkg::S_W'(py1_s3) + qbf_pkg::S_W'(py2_s3);
	assign pt_x  = sum_x[qbf_pkg::FRAC_W +: qbf_pkg::COORD_W];
	assign pt_y  = sum_y[qbf_pkg::FRAC_W +: qbf_pkg::COORD_W];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sx_q     <= curve.start_x;
			sy_q     <= curve.start_y;
			cx_q     <= curve.ctrl_x;
			cy_q     <= curve.ctrl_y;
			fx_q     <= curve.finish_x;
			fy_q     <= curve.finish_y;
			n_q      <= n_clamped;
			qd_q     <= qbf_pkg::ONE_Q16;
			rem_q    <= '0;
			u_q      <= '0;
			acc_q    <= '0;
		end else if (cmd.div_step) begin
			qd_q  <= {qd_q[qbf_pkg::U_W-2:0], rem_ge};
			rem_q <= rem_ge ? NW'(rem_sh - (NW+1)'(n_q)) : NW'(rem_sh);
		end else if (cmd.issue) begin
			u_q   <= u_nxt;
			acc_q <= acc_carry ? NW'(acc_sum - (NW+1)'(n_q)) : NW'(acc_sum);
		end
		if (en) begin
			u_s1    <= u_nxt;
			v_s1    <= qbf_pkg::ONE_Q16 - u_nxt;
			last_s1 <= cmd.last;
			w0_s2   <= vv[qbf_pkg::FRAC_W +: qbf_pkg::W_W];
			w1_s2   <= uv[qbf_pkg::FRAC_W-1 +: qbf_pkg::W_W];
			w2_s2   <= uu[qbf_pkg::FRAC_W +: qbf_pkg::W_W];
			last_s2 <= last_s1;
			px0_s3  <= sx_q * $signed({1'b0, w0_s2});
			px1_s3  <= cx_q * $signed({1'b0, w1_s2});
			px2_s3  <= fx_q * $signed({1'b0, w2_s2});
			py0_s3  <= sy_q * $signed({1'b0, w0_s2});
			py1_s3  <= cy_q * $signed({1'b0, w1_s2});
			py2_s3  <= fy_q * $signed({1'b0, w2_s2});
			last_s3 <= last_s2;
		end
		if (cmd.load) begin
			prev_x_q <= curve.start_x;
			prev_y_q <= curve.start_y;
		end else if (en && valid_s3) begin
			seg.seg_from_x   <= prev_x_q;
			seg.seg_from_y   <= prev_y_q;
			seg.seg_to_x     <= pt_x;
			seg.seg_to_y     <= pt_y;
			seg.last_segment <= last_s3;
			prev_x_q         <= pt_x;
			prev_y_q         <= pt_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= cmd.issue;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	assign seg.valid = out_valid_q;
	assign sts.en    = en;
	assign sts.busy  = valid_s1 || valid_s2 || valid_s3 || out_valid_q;
	assign sts.n     = n_q;

endmodule

[src/qbf_ctrl.sv]
// sequencing state machine: accept, divide, issue points, drain
module qbf_ctrl #(
	parameter int MAX_SEGMENTS = qbf_pkg::MAX_SEGMENTS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  qbf_pkg::qbf_sts_t sts,
	output qbf_pkg::qbf_cmd_t cmd
);
	localparam int NW = $clog2(MAX_SEGMENTS + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_DIV   = 2'd1;
	localparam logic [1:0] S_RUN   = 2'd2;
	localparam logic [1:0] S_DRAIN = 2'd3;

	logic [1:0]                      state_q;
	logic [qbf_pkg::DIV_CNT_W-1:0]   div_cnt_q;
	logic [NW-1:0]                   cnt_q;
	logic                            last_pt;

	assign last_pt = (qbf_pkg::CNT_W'(cnt_q) + qbf_pkg::CNT_W'(1)) == sts.n;

	assign in_ready     = state_q == S_IDLE;
	assign cmd.load     = (state_q == S_IDLE) && in_valid;
	assign cmd.div_step = state_q == S_DIV;
	assign cmd.issue    = (state_q == S_RUN) && sts.en;
	assign cmd.last     = last_pt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
			cnt_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q   <= S_DIV;
						div_cnt_q <= '0;
					end
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == qbf_pkg::DIV_CNT_W'(qbf_pkg::DIV_STEPS - 1)) begin
						state_q <= S_RUN;
						cnt_q   <= '0;
					end
				end
				S_RUN: begin
					if (sts.en) begin
						cnt_q <= cnt_q + 1'b1;
						if (last_pt) begin
							state_q <= S_DRAIN;
						end
					end
				end
				S_DRAIN: begin
					if (!sts.busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a new curve never finds points of the previous one in flight
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !sts.busy)
		else $error("pipeline busy while idle");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && cmd.last) |=> (state_q == S_DRAIN))
		else $error("last point not followed by drain");

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (div_cnt_q < qbf_pkg::DIV_CNT_W'(qbf_pkg::DIV_STEPS)))
		else $error("divider step count overrun");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN) |-> (qbf_pkg::CNT_W'(cnt_q) < sts.n))
		else $error("issued more points than segments");

endmodule

[src/quadratic_bezier_flattener_unit.sv]
// quadratic bezier flattener top level: controller and datapath
//
//  channel  dir  handshake      payload
//  curve    in   valid/ready    start, ctrl, finish points (q16.8), segment_count
//  seg      out  valid/ready    from and to points (q16.8), last_segment
//
// one curve is taken at a time; a curve of n segments passes through these steps in
// order: accept, the bit-serial restoring divider that works out 65536 / n, issue of
// n points at one point a cycle while the output is not stalled, then a drain of the
// 3 pipeline stages plus the output register until the pipeline is seen empty
// arst_n clears the state machine and all stage valid bits; payload is not reset
// a stalled result request freezes the whole point pipeline; nothing is dropped
module quadratic_bezier_flattener_unit #(
	parameter int MAX_SEGMENTS = qbf_pkg::MAX_SEGMENTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	qbf_in_if.sink     curve,
	qbf_out_if.source  seg
);
	qbf_pkg::qbf_curve_t curve_pl;
	qbf_pkg::qbf_cmd_t   cmd;
	qbf_pkg::qbf_sts_t   sts;
	logic                in_ready;

	// gather the request payload for the datapath
	assign curve_pl.start_x       = curve.start_x;
	assign curve_pl.start_y       = curve.start_y;
	assign curve_pl.ctrl_x        = curve.ctrl_x;
	assign curve_pl.ctrl_y        = curve.ctrl_y;
	assign curve_pl.finish_x      = curve.finish_x;
	assign curve_pl.finish_y      = curve.finish_y;
	assign curve_pl.segment_count = curve.segment_count;

	assign curve.ready = in_ready;

	// sequencing: accept, divide, issue, drain
	qbf_ctrl #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (curve.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic: divider, accumulator, weights, products, sum and output
	qbf_datapath #(
		.MAX_SEGMENTS (MAX_SEGMENTS)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.curve  (curve_pl),
		.cmd    (cmd),
		.sts    (sts),
		.seg    (seg)
	);

endmodule
